// File: rtl/scaled_blit_address_generator_defines.svh
// Assertion macros shared by the scaled blit address generator RTL
`ifndef SCALED_BLIT_ADDRESS_GENERATOR_DEFINES_SVH
`define SCALED_BLIT_ADDRESS_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked on aclk and off during reset
`define SBAG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk and off during reset
`define SBAG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sbag_pkg.sv
// Shared types and constants for the scaled blit address generator
package sbag_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ADDR_W         = 32;
    localparam int PITCH_W        = 18;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;
    // 4 bytes per pixel
    localparam int PIXEL_SHIFT    = 2;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLIP_LEFT   = 3'd0,
        REG_CLIP_RIGHT  = 3'd1,
        REG_CLIP_TOP    = 3'd2,
        REG_CLIP_BOTTOM = 3'd3,
        REG_SRC_BASE    = 3'd4,
        REG_SRC_PITCH   = 3'd5,
        REG_DST_BASE    = 3'd6,
        REG_DST_PITCH   = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_X,
        ST_WAIT_X,
        ST_DIV_Y,
        ST_WAIT_Y,
        ST_MUL,
        ST_SRC,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;
        logic div_go;
        logic div_sel_y;
        logic cap_scale;
        logic mul;
        logic src;
        logic emit;
    } sbag_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic active;
        logic div_busy;
        logic out_free;
    } sbag_sts_t;

endpackage

// File: rtl/sbag_div.sv
// Restoring divider, one quotient bit per cycle
`include "scaled_blit_address_generator_defines.svh"

module sbag_div #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 15
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    // One restoring step: shift in next numerator bit, subtract if it fits
    always_comb begin
        shifted = {rem_reg, quo_reg[NUM_W-1]};
        diff    = shifted - {1'b0, den_reg};
        ge      = (shifted >= {1'b0, den_reg});
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        if (start) begin
            cnt_next = CNT_W'(NUM_W);
            quo_next = num;
            rem_next = '0;
            den_next = den;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - CNT_W'(1);
            quo_next = {quo_reg[NUM_W-2:0], ge};
            rem_next = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

    // Hold the count under reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Advance the working registers
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = (cnt_reg != '0);
    assign quot = quo_reg;

    `SBAG_ASSERT_IMP(a_div_no_restart, start, cnt_reg == '0, "divider restarted while busy")

endmodule

// File: rtl/sbag_datapath.sv
// Datapath: config registers, clipping, scale ratios and address arithmetic
`include "scaled_blit_address_generator_defines.svh"

module sbag_datapath #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  sbag_pkg::sbag_cmd_t                       cmd,
    output sbag_pkg::sbag_sts_t                       sts,
    input  logic                                      cfg_we,
    input  logic [sbag_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [sbag_pkg::CFG_DATA_W-1:0]           cfg_data,
    input  logic signed [COORD_BITS-1:0]              s_src_x,
    input  logic signed [COORD_BITS-1:0]              s_src_y,
    input  logic [COORD_BITS-2:0]                     s_src_w,
    input  logic [COORD_BITS-2:0]                     s_src_h,
    input  logic signed [COORD_BITS-1:0]              s_dst_x,
    input  logic signed [COORD_BITS-1:0]              s_dst_y,
    input  logic [COORD_BITS-2:0]                     s_dst_w,
    input  logic [COORD_BITS-2:0]                     s_dst_h,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic [sbag_pkg::ADDR_W-1:0]               m_src_addr,
    output logic [sbag_pkg::ADDR_W-1:0]               m_dst_addr,
    output logic                                      m_last
);
    import sbag_pkg::*;

    localparam int CW     = COORD_BITS;
    localparam int SW     = COORD_BITS - 1;
    localparam int NUM_W  = SW + FRAC_BITS;
    localparam int PROD_W = SW + NUM_W;

    // Configuration registers
    logic signed [CW-1:0] clip_left_reg, clip_right_reg, clip_top_reg, clip_bottom_reg;
    logic [ADDR_W-1:0]    src_base_reg, dst_base_reg;
    logic [PITCH_W-1:0]   src_pitch_reg, dst_pitch_reg;

    // Blit state
    logic                 active_reg, active_next;
    logic signed [CW-1:0] left_reg, right_reg, bottom_reg;
    logic signed [CW-1:0] row_reg, row_next, col_reg, col_next;
    logic signed [CW-1:0] org_sx_reg, org_sy_reg, org_dx_reg, org_dy_reg;
    logic [SW-1:0]        sw_reg, sh_reg, dw_reg, dh_reg;
    logic [NUM_W-1:0]     xs_reg, ys_reg;

    // Address pipeline registers
    logic [PROD_W-1:0]    px_reg, py_reg;
    logic [ADDR_W-1:0]    dprod_reg, spro_reg, sx4_reg;
    logic                 m_valid_reg;
    logic [ADDR_W-1:0]    m_src_addr_reg, m_dst_addr_reg;
    logic                 m_last_reg;

    // Start-item clipping
    logic signed [CW:0]   dx_end, dy_end, clip_r_ext, clip_b_ext, r_wide, b_wide;
    logic signed [CW-1:0] clip_l, clip_t, clip_r, clip_b;
    logic                 nonempty;

    // Step arithmetic
    logic signed [CW:0]   ox_full, oy_full, sx, sy, col_inc, row_inc;
    logic signed [CW:0]   right_ext, bottom_ext;
    logic [SW-1:0]        ox, oy, offx, offy;
    logic [ADDR_W-1:0]    row32, col32, sx32, sy32, dpitch32, spitch32;
    logic                 fin;

    // Divider hookup
    logic [NUM_W-1:0]     div_num, div_quot;
    logic [SW-1:0]        div_den;
    logic                 div_busy;

    // Clip the destination rectangle against the clip registers
    always_comb begin
        dx_end     = $signed({s_dst_x[CW-1], s_dst_x}) + $signed({2'b00, s_dst_w});
        dy_end     = $signed({s_dst_y[CW-1], s_dst_y}) + $signed({2'b00, s_dst_h});
        clip_r_ext = $signed({clip_right_reg[CW-1], clip_right_reg});
        clip_b_ext = $signed({clip_bottom_reg[CW-1], clip_bottom_reg});
        clip_l     = (clip_left_reg > s_dst_x) ? clip_left_reg : s_dst_x;
        clip_t     = (clip_top_reg > s_dst_y) ? clip_top_reg : s_dst_y;
        r_wide     = (clip_r_ext < dx_end) ? clip_r_ext : dx_end;
        b_wide     = (clip_b_ext < dy_end) ? clip_b_ext : dy_end;
        clip_r     = r_wide[CW-1:0];
        clip_b     = b_wide[CW-1:0];
        nonempty   = (clip_l < clip_r) && (clip_t < clip_b) &&
                     (s_dst_w != '0) && (s_dst_h != '0);
    end

    // Select divider operands for the x or y ratio
    assign div_num = cmd.div_sel_y ? {sh_reg, {FRAC_BITS{1'b0}}} : {sw_reg, {FRAC_BITS{1'b0}}};
    assign div_den = cmd.div_sel_y ? dh_reg : dw_reg;

    sbag_div #(
        .NUM_W (NUM_W),
        .DEN_W (SW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_go),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    // Offsets into the destination rectangle and scaled source offsets
    always_comb begin
        ox_full  = $signed({col_reg[CW-1], col_reg}) - $signed({org_dx_reg[CW-1], org_dx_reg});
        oy_full  = $signed({row_reg[CW-1], row_reg}) - $signed({org_dy_reg[CW-1], org_dy_reg});
        ox       = ox_full[SW-1:0];
        oy       = oy_full[SW-1:0];
        offx     = px_reg[FRAC_BITS +: SW];
        offy     = py_reg[FRAC_BITS +: SW];
        sx       = $signed({org_sx_reg[CW-1], org_sx_reg}) + $signed({2'b00, offx});
        sy       = $signed({org_sy_reg[CW-1], org_sy_reg}) + $signed({2'b00, offy});
        row32    = {{(ADDR_W-CW){row_reg[CW-1]}}, row_reg};
        col32    = {{(ADDR_W-CW){col_reg[CW-1]}}, col_reg};
        sx32     = {{(ADDR_W-CW-1){sx[CW]}}, sx};
        sy32     = {{(ADDR_W-CW-1){sy[CW]}}, sy};
        dpitch32 = {{(ADDR_W-PITCH_W){1'b0}}, dst_pitch_reg};
        spitch32 = {{(ADDR_W-PITCH_W){1'b0}}, src_pitch_reg};
    end

    // Walk the clipped area row-major and flag the final request
    always_comb begin
        col_inc     = $signed({col_reg[CW-1], col_reg}) + $signed((CW+1)'(1));
        row_inc     = $signed({row_reg[CW-1], row_reg}) + $signed((CW+1)'(1));
        right_ext   = $signed({right_reg[CW-1], right_reg});
        bottom_ext  = $signed({bottom_reg[CW-1], bottom_reg});
        fin         = (col_inc == right_ext) && (row_inc == bottom_ext);
        active_next = active_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cmd.start) begin
            active_next = nonempty;
            col_next    = clip_l;
            row_next    = clip_t;
        end else if (cmd.emit) begin
            if (col_inc >= right_ext) begin
                col_next = left_reg;
                row_next = row_inc[CW-1:0];
                if (row_inc >= bottom_ext) begin
                    active_next = 1'b0;
                end
            end else begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_left_reg   <= '0;
            clip_right_reg  <= '0;
            clip_top_reg    <= '0;
            clip_bottom_reg <= '0;
            src_base_reg    <= '0;
            src_pitch_reg   <= '0;
            dst_base_reg    <= '0;
            dst_pitch_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CLIP_LEFT:   clip_left_reg   <= cfg_data[CW-1:0];
                REG_CLIP_RIGHT:  clip_right_reg  <= cfg_data[CW-1:0];
                REG_CLIP_TOP:    clip_top_reg    <= cfg_data[CW-1:0];
                REG_CLIP_BOTTOM: clip_bottom_reg <= cfg_data[CW-1:0];
                REG_SRC_BASE:    src_base_reg    <= cfg_data[ADDR_W-1:0];
                REG_SRC_PITCH:   src_pitch_reg   <= cfg_data[PITCH_W-1:0];
                REG_DST_BASE:    dst_base_reg    <= cfg_data[ADDR_W-1:0];
                REG_DST_PITCH:   dst_pitch_reg   <= cfg_data[PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    // Control state: blit active flag and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Latch the start request and walk position
    always_ff @(posedge aclk) begin
        row_reg <= row_next;
        col_reg <= col_next;
        if (cmd.start) begin
            left_reg   <= clip_l;
            right_reg  <= clip_r;
            bottom_reg <= clip_b;
            org_sx_reg <= s_src_x;
            org_sy_reg <= s_src_y;
            org_dx_reg <= s_dst_x;
            org_dy_reg <= s_dst_y;
            sw_reg     <= s_src_w;
            sh_reg     <= s_src_h;
            dw_reg     <= s_dst_w;
            dh_reg     <= s_dst_h;
        end
        if (cmd.cap_scale) begin
            if (cmd.div_sel_y) begin
                ys_reg <= div_quot;
            end else begin
                xs_reg <= div_quot;
            end
        end
    end

    // Address pipeline: products, then source coordinates, then sums
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            px_reg    <= ox * xs_reg;
            py_reg    <= oy * ys_reg;
            dprod_reg <= ADDR_W'(row32 * dpitch32);
        end
        if (cmd.src) begin
            spro_reg <= ADDR_W'(sy32 * spitch32);
            sx4_reg  <= sx32 << PIXEL_SHIFT;
        end
        if (cmd.emit) begin
            m_src_addr_reg <= src_base_reg + spro_reg + sx4_reg;
            m_dst_addr_reg <= dst_base_reg + dprod_reg + (col32 << PIXEL_SHIFT);
            m_last_reg     <= fin;
        end
    end

    assign sts.active   = active_reg;
    assign sts.div_busy = div_busy;
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid    = m_valid_reg;
    assign m_src_addr = m_src_addr_reg;
    assign m_dst_addr = m_dst_addr_reg;
    assign m_last     = m_last_reg;

    `SBAG_ASSERT_IMP(a_walk_in_bounds, active_reg, (col_reg >= left_reg) && (col_reg < right_reg) && (row_reg < bottom_reg), "walk position left the clipped area")
    `SBAG_ASSERT_IMP(a_emit_into_free, cmd.emit, !m_valid_reg || m_ready, "result overwrote a pending request")
    `SBAG_ASSERT_NXT(a_last_ends_blit, cmd.emit && fin, !active_reg, "blit still active after last request")

endmodule

// File: rtl/sbag_ctrl.sv
// Controller: sequences start handling, ratio division and request generation
module sbag_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_op,
    input  sbag_pkg::sbag_sts_t sts,
    output sbag_pkg::sbag_cmd_t cmd
);
    import sbag_pkg::*;

    state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_op == OP_START) begin
                        cmd.start  = 1'b1;
                        state_next = ST_CHECK;
                    end else if (sts.active) begin
                        state_next = ST_MUL;
                    end
                end
            end
            // Drop an empty blit, otherwise compute both ratios
            ST_CHECK: begin
                state_next = sts.active ? ST_DIV_X : ST_IDLE;
            end
            ST_DIV_X: begin
                cmd.div_go = 1'b1;
                state_next = ST_WAIT_X;
            end
            ST_WAIT_X: begin
                if (!sts.div_busy) begin
                    cmd.cap_scale = 1'b1;
                    state_next    = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                cmd.div_go    = 1'b1;
                cmd.div_sel_y = 1'b1;
                state_next    = ST_WAIT_Y;
            end
            ST_WAIT_Y: begin
                cmd.div_sel_y = 1'b1;
                if (!sts.div_busy) begin
                    cmd.cap_scale = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_SRC;
            end
            ST_SRC: begin
                cmd.src    = 1'b1;
                state_next = ST_EMIT;
            end
            // Load the output register once it is free, then advance
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

// File: rtl/scaled_blit_address_generator.sv
// Step request: the multiply, coordinate and address-sum stages of the shared datapath form
// the result, which waits in the emit state for a free output register; no new request is
// accepted before then. Start request: an empty clipped area ends after the check state,
// else the one-bit-per-cycle divider runs once per axis to form the x and y scale ratios.
// The output register lets the next request be accepted while a result waits.
// Synchronous active-low reset clears all configuration registers and leaves the engine idle.
`include "scaled_blit_address_generator_defines.svh"

module scaled_blit_address_generator #(
    parameter int COORD_BITS = sbag_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sbag_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sbag_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sbag_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_op,
    input  logic signed [COORD_BITS-1:0]         s_src_x,
    input  logic signed [COORD_BITS-1:0]         s_src_y,
    input  logic [COORD_BITS-2:0]                s_src_w,
    input  logic [COORD_BITS-2:0]                s_src_h,
    input  logic signed [COORD_BITS-1:0]         s_dst_x,
    input  logic signed [COORD_BITS-1:0]         s_dst_y,
    input  logic [COORD_BITS-2:0]                s_dst_w,
    input  logic [COORD_BITS-2:0]                s_dst_h,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [sbag_pkg::ADDR_W-1:0]          m_src_addr,
    output logic [sbag_pkg::ADDR_W-1:0]          m_dst_addr,
    output logic                                 m_last
);
    import sbag_pkg::*;

    sbag_cmd_t cmd;
    sbag_sts_t sts;

    // Registers take a write in any cycle
    assign cfg_ready = 1'b1;

    sbag_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .sts     (sts),
        .cmd     (cmd)
    );

    sbag_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_src_x    (s_src_x),
        .s_src_y    (s_src_y),
        .s_src_w    (s_src_w),
        .s_src_h    (s_src_h),
        .s_dst_x    (s_dst_x),
        .s_dst_y    (s_dst_y),
        .s_dst_w    (s_dst_w),
        .s_dst_h    (s_dst_h),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_src_addr (m_src_addr),
        .m_dst_addr (m_dst_addr),
        .m_last     (m_last)
    );

endmodule

// File: sim/scaled_blit_checker.sv
// Checker for the scaled blit address generator: predicts copy requests and compares them
module scaled_blit_checker (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_valid,
    input  logic                                     cfg_ready,
    input  logic [sbag_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [sbag_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic                                     s_valid,
    input  logic                                     s_ready,
    input  logic                                     s_op,
    input  logic signed [sbag_pkg::COORD_BITS_DEF-1:0] s_src_x,
    input  logic signed [sbag_pkg::COORD_BITS_DEF-1:0] s_src_y,
    input  logic [sbag_pkg::COORD_BITS_DEF-2:0]      s_src_w,
    input  logic [sbag_pkg::COORD_BITS_DEF-2:0]      s_src_h,
    input  logic signed [sbag_pkg::COORD_BITS_DEF-1:0] s_dst_x,
    input  logic signed [sbag_pkg::COORD_BITS_DEF-1:0] s_dst_y,
    input  logic [sbag_pkg::COORD_BITS_DEF-2:0]      s_dst_w,
    input  logic [sbag_pkg::COORD_BITS_DEF-2:0]      s_dst_h,
    input  logic                                     m_valid,
    input  logic                                     m_ready,
    input  logic [sbag_pkg::ADDR_W-1:0]              m_src_addr,
    input  logic [sbag_pkg::ADDR_W-1:0]              m_dst_addr,
    input  logic                                     m_last,
    output int                                       mismatches,
    output int                                       copies_due
);
    timeunit 1ns;
    timeprecision 1ps;
    import sbag_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;

    typedef struct packed {
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic              fin;
    } copy_req_t;

    // Copy requests predicted but not yet seen on the result channel
    copy_req_t expected_copies[$];

    // Mirror of the configuration registers
    int                 clip_left_q, clip_right_q, clip_top_q, clip_bottom_q;
    logic [ADDR_W-1:0]  src_base_q, dst_base_q;
    logic [PITCH_W-1:0] src_pitch_q, dst_pitch_q;

    // Walk over the clipped destination area
    bit          walking;
    int          cur_row, cur_col, left_edge, right_edge, bottom_edge;
    logic [63:0] x_ratio, y_ratio;
    int          org_src_x, org_src_y, org_dst_x, org_dst_y;

    function automatic int coord16(logic [CFG_DATA_W-1:0] d);
        return int'($signed(d[COORD_BITS_DEF-1:0]));
    endfunction

    task automatic clear_model();
        clip_left_q   = 0;
        clip_right_q  = 0;
        clip_top_q    = 0;
        clip_bottom_q = 0;
        src_base_q    = '0;
        dst_base_q    = '0;
        src_pitch_q   = '0;
        dst_pitch_q   = '0;
        walking       = 1'b0;
        cur_row       = 0;
        cur_col       = 0;
        left_edge     = 0;
        right_edge    = 0;
        bottom_edge   = 0;
        x_ratio       = '0;
        y_ratio       = '0;
        org_src_x     = 0;
        org_src_y     = 0;
        org_dst_x     = 0;
        org_dst_y     = 0;
        mismatches    = 0;
        expected_copies.delete();
    endtask

    // Keep only as many data bits as the register holds
    task automatic store_register();
        case (cfg_idx_t'(cfg_index))
            REG_CLIP_LEFT:   clip_left_q   = coord16(cfg_data);
            REG_CLIP_RIGHT:  clip_right_q  = coord16(cfg_data);
            REG_CLIP_TOP:    clip_top_q    = coord16(cfg_data);
            REG_CLIP_BOTTOM: clip_bottom_q = coord16(cfg_data);
            REG_SRC_BASE:    src_base_q    = cfg_data[ADDR_W-1:0];
            REG_SRC_PITCH:   src_pitch_q   = cfg_data[PITCH_W-1:0];
            REG_DST_BASE:    dst_base_q    = cfg_data[ADDR_W-1:0];
            REG_DST_PITCH:   dst_pitch_q   = cfg_data[PITCH_W-1:0];
            default: ;
        endcase
    endtask

    // Clip the destination rectangle and latch the scale ratios
    task automatic begin_blit();
        int dx0, dy0, l, r, t, b;
        dx0 = int'(s_dst_x);
        dy0 = int'(s_dst_y);
        l = (clip_left_q > dx0) ? clip_left_q : dx0;
        r = (clip_right_q < dx0 + int'(s_dst_w)) ? clip_right_q : dx0 + int'(s_dst_w);
        t = (clip_top_q > dy0) ? clip_top_q : dy0;
        b = (clip_bottom_q < dy0 + int'(s_dst_h)) ? clip_bottom_q : dy0 + int'(s_dst_h);
        walking = 1'b0;
        if (l >= r || t >= b || s_dst_w == 0 || s_dst_h == 0) begin
            return;
        end
        x_ratio     = (64'(s_src_w) << FRAC) / 64'(s_dst_w);
        y_ratio     = (64'(s_src_h) << FRAC) / 64'(s_dst_h);
        org_src_x   = int'(s_src_x);
        org_src_y   = int'(s_src_y);
        org_dst_x   = dx0;
        org_dst_y   = dy0;
        left_edge   = l;
        right_edge  = r;
        bottom_edge = b;
        cur_row     = t;
        cur_col     = l;
        walking     = 1'b1;
    endtask

    // Predict the copy request for the current pixel, then advance row-major
    task automatic emit_copy();
        logic [63:0] scaled_x, scaled_y;
        logic [31:0] sx, sy;
        copy_req_t   req;
        scaled_x = 64'(unsigned'(cur_col - org_dst_x)) * x_ratio;
        scaled_y = 64'(unsigned'(cur_row - org_dst_y)) * y_ratio;
        // offset truncates first, then adds to the origin
        sx = unsigned'(org_src_x) + 32'(scaled_x >> FRAC);
        sy = unsigned'(org_src_y) + 32'(scaled_y >> FRAC);
        req.src_addr = src_base_q + sy * 32'(src_pitch_q) + (sx << PIXEL_SHIFT);
        req.dst_addr = dst_base_q + unsigned'(cur_row) * 32'(dst_pitch_q)
                     + (unsigned'(cur_col) << PIXEL_SHIFT);
        req.fin = (cur_col + 1 == right_edge) && (cur_row + 1 == bottom_edge);
        expected_copies.push_back(req);
        cur_col++;
        if (cur_col >= right_edge) begin
            cur_col = left_edge;
            cur_row++;
            if (cur_row >= bottom_edge) begin
                walking = 1'b0;
            end
        end
    endtask

    task automatic check_copy();
        copy_req_t want;
        if (expected_copies.size() == 0) begin
            $error("copy request with none expected: src_addr %h dst_addr %h last %b",
                   m_src_addr, m_dst_addr, m_last);
            mismatches++;
            return;
        end
        want = expected_copies.pop_front();
        if (m_src_addr !== want.src_addr) begin
            $error("src_addr expected %h actual %h", want.src_addr, m_src_addr);
            mismatches++;
        end
        if (m_dst_addr !== want.dst_addr) begin
            $error("dst_addr expected %h actual %h", want.dst_addr, m_dst_addr);
            mismatches++;
        end
        if (m_last !== want.fin) begin
            $error("last expected %b actual %b", want.fin, m_last);
            mismatches++;
        end
    endtask

    // Sample all three channels on the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_model();
        end else begin
            if (m_valid && m_ready) begin
                check_copy();
            end
            if (cfg_valid && cfg_ready) begin
                store_register();
            end
            if (s_valid && s_ready) begin
                if (s_op == OP_START) begin
                    begin_blit();
                end else if (walking) begin
                    emit_copy();
                end
            end
        end
        copies_due = expected_copies.size();
    end

endmodule

// File: sim/scaled_blit_address_generator_tb.sv
// Testbench top for the scaled blit address generator: clock, reset, stimulus and verdict
module scaled_blit_address_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sbag_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    // longest start request plus margin
    localparam int START_SETTLE    = 2 * (COORD_BITS_DEF - 1 + FRAC_BITS_DEF) + 12;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int ITEM_TARGET     = 1200;

    logic                              aclk;
    logic                              aresetn;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [CFG_IDX_W-1:0]              cfg_index;
    logic [CFG_DATA_W-1:0]             cfg_data;
    logic                              s_valid;
    logic                              s_ready;
    logic                              s_op;
    logic signed [COORD_BITS_DEF-1:0]  s_src_x;
    logic signed [COORD_BITS_DEF-1:0]  s_src_y;
    logic [COORD_BITS_DEF-2:0]         s_src_w;
    logic [COORD_BITS_DEF-2:0]         s_src_h;
    logic signed [COORD_BITS_DEF-1:0]  s_dst_x;
    logic signed [COORD_BITS_DEF-1:0]  s_dst_y;
    logic [COORD_BITS_DEF-2:0]         s_dst_w;
    logic [COORD_BITS_DEF-2:0]         s_dst_h;
    logic                              m_valid;
    logic                              m_ready;
    logic [ADDR_W-1:0]                 m_src_addr;
    logic [ADDR_W-1:0]                 m_dst_addr;
    logic                              m_last;

    int mismatches;
    int copies_due;
    int cycle_count;
    int items_sent;
    int sender_run_left;
    int receiver_run_left;
    bit hold_off_req;
    // Clip window as last written, used to size each blit
    int win_l, win_r, win_t, win_b;

    scaled_blit_address_generator DUT (.*);

    scaled_blit_checker u_checker (.*);

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Bound the run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("scaled_blit_address_generator_tb: errors");
            $finish;
        end
    end

    // Result side: random stalls, quiet stretches and one long hold-off on request
    initial begin : receiver
        int pick;
        int gap;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
                hold_off_req = 1'b0;
            end else if (receiver_run_left > 0) begin
                m_ready <= 1'b1;
                receiver_run_left--;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    receiver_run_left = $urandom_range(20, 80);
                    m_ready <= 1'b1;
                end else if (pick < 60) begin
                    m_ready <= 1'b1;
                end else begin
                    gap = (pick < 96) ? $urandom_range(1, 3) : $urandom_range(20, 60);
                    m_ready <= 1'b0;
                    repeat (gap - 1) @(negedge aclk);
                end
            end
        end
    end

    function automatic int clamp16(int v);
        if (v < -32768) return -32768;
        if (v > 32767) return 32767;
        return v;
    endfunction

    function automatic int clipped_area(int dx, int dy, int dw, int dh);
        int l, r, t, b;
        l = (win_l > dx) ? win_l : dx;
        r = (win_r < dx + dw) ? win_r : dx + dw;
        t = (win_t > dy) ? win_t : dy;
        b = (win_b < dy + dh) ? win_b : dy + dh;
        if (l >= r || t >= b) return 0;
        return (r - l) * (b - t);
    endfunction

    function automatic int sender_gap();
        int pick;
        if (sender_run_left > 0) begin
            sender_run_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            sender_run_left = $urandom_range(15, 60);
            return 0;
        end
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Offer one request; called and returns at a falling edge
    task automatic send_item(op_t op, int sx, int sy, int sw, int sh,
                             int dx, int dy, int dw, int dh);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_op    <= op;
        s_src_x <= sx[15:0];
        s_src_y <= sy[15:0];
        s_src_w <= sw[14:0];
        s_src_h <= sh[14:0];
        s_dst_x <= dx[15:0];
        s_dst_y <= dy[15:0];
        s_dst_w <= dw[14:0];
        s_dst_h <= dh[14:0];
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Step requests carry junk in the unused fields
    task automatic send_step();
        send_item(OP_STEP, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
    endtask

    // Start a blit, then issue the given number of steps (negative: the whole area)
    task automatic blit(int sx, int sy, int sw, int sh, int dx, int dy, int dw, int dh,
                        int steps);
        int area;
        area = clipped_area(dx, dy, dw, dh);
        if (steps < 0) steps = area;
        send_item(OP_START, sx, sy, sw, sh, dx, dy, dw, dh);
        repeat (steps) send_step();
        items_sent += 1 + ((steps < area) ? steps : area);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Write all registers; upper data bits are junk the block must drop
    task automatic configure(int l, int r, int t, int b, logic [31:0] sbase,
                             logic [17:0] spitch, logic [31:0] dbase, logic [17:0] dpitch);
        win_l = l;
        win_r = r;
        win_t = t;
        win_b = b;
        write_reg(REG_CLIP_LEFT,   {16'($urandom), l[15:0]});
        write_reg(REG_CLIP_RIGHT,  {16'($urandom), r[15:0]});
        write_reg(REG_CLIP_TOP,    {16'($urandom), t[15:0]});
        write_reg(REG_CLIP_BOTTOM, {16'($urandom), b[15:0]});
        write_reg(REG_SRC_BASE,    sbase);
        write_reg(REG_SRC_PITCH,   {14'($urandom), spitch});
        write_reg(REG_DST_BASE,    dbase);
        write_reg(REG_DST_PITCH,   {14'($urandom), dpitch});
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every predicted request, then let a start finish
    task automatic drain();
        s_valid <= 1'b0;
        while (copies_due != 0) @(negedge aclk);
        repeat (START_SETTLE) @(negedge aclk);
    endtask

    task automatic random_blit();
        int dx, dy, dw, dh, sw, sh, area, steps, pick;
        bit narrow;
        narrow = (win_r - win_l <= 8) && (win_b - win_t <= 8);
        pick = $urandom_range(0, 99);
        if (narrow && pick < 15) begin
            // huge destination, bounded by the small window
            dw = $urandom_range(0, 32767);
            dh = $urandom_range(0, 32767);
            dx = clamp16(win_l - $urandom_range(0, dw));
            dy = clamp16(win_t - $urandom_range(0, dh));
        end else begin
            dw = $urandom_range(0, 6);
            dh = $urandom_range(0, 5);
            if (narrow) begin
                dx = clamp16(win_l + $urandom_range(0, 9) - 6);
                dy = clamp16(win_t + $urandom_range(0, 7) - 5);
            end else begin
                dx = $urandom_range(0, 65535) - 32768;
                dy = $urandom_range(0, 65535) - 32768;
            end
        end
        sw = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 12) : $urandom_range(0, 32767);
        sh = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 12) : $urandom_range(0, 32767);
        area = clipped_area(dx, dy, dw, dh);
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            steps = area;
        end else if (pick < 90) begin
            steps = $urandom_range(0, area);
        end else begin
            steps = area + $urandom_range(1, 3);
        end
        blit($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768, sw, sh,
             dx, dy, dw, dh, steps);
    endtask

    initial begin : stimulus
        int l, t, phase_items;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_CLIP_LEFT;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_op      = OP_STEP;
        s_src_x   = '0;
        s_src_y   = '0;
        s_src_w   = '0;
        s_src_h   = '0;
        s_dst_x   = '0;
        s_dst_y   = '0;
        s_dst_w   = '0;
        s_dst_h   = '0;
        win_l = 0;
        win_r = 0;
        win_t = 0;
        win_b = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset clip window is empty: a start yields nothing, a step while idle neither
        blit(1, 2, 3, 4, 0, 0, 5, 5, 1);
        drain();

        configure(-2, 2, -1, 1, 32'h1000_0000, 18'd400, 32'h2000_0000, 18'd1024);
        // zero width, zero height, fully outside the window
        blit(0, 0, 4, 4, 0, 0, 0, 3, 1);
        blit(0, 0, 4, 4, 0, 0, 3, 0, 0);
        blit(0, 0, 4, 4, 32767, 32767, 32767, 32767, 0);
        // extreme source and destination fields
        blit(-32768, -32768, 32767, 32767, -32768, -1, 32767, 32767, -1);
        blit(32767, 32767, 0, 0, -1, 0, 3, 1, -1);
        // negative source origin, replaced by a new start mid-blit
        blit(-5, -7, 7, 3, -2, -1, 4, 2, 2);
        blit(-3, 10, 2, 5, -3, -2, 6, 4, -1);
        drain();

        for (int p = 0; items_sent < ITEM_TARGET; p++) begin
            phase_items = 120;
            case (p)
                0: configure(-32768, 32767, -32768, 32767,
                             32'hFFFF_FFFF, 18'd262140, 32'hFFFF_FFFF, 18'd262140);
                1: configure(-32768, -32765, -32768, -32766, '0, '0, '0, '0);
                2: begin
                    // inverted window: every start clips to nothing
                    configure(5, -5, 3, -3, $urandom, 18'($urandom), $urandom, 18'($urandom));
                    phase_items = 30;
                end
                3: configure(32764, 32767, 32765, 32767,
                             $urandom, 18'($urandom), $urandom, 18'($urandom));
                default: begin
                    l = $urandom_range(0, 65520) - 32768;
                    t = $urandom_range(0, 65520) - 32768;
                    configure(l, l + $urandom_range(1, 6), t, t + $urandom_range(1, 4),
                              $urandom, 18'($urandom), $urandom, 18'($urandom));
                end
            endcase
            if (p == 4) begin
                hold_off_req = 1'b1;
            end
            phase_items += items_sent;
            while (items_sent < phase_items) random_blit();
            drain();
        end

        if (copies_due != 0) begin
            $error("%0d copy requests never arrived", copies_due);
        end
        if (mismatches == 0 && copies_due == 0) begin
            $display("scaled_blit_address_generator_tb: clean");
        end else begin
            $display("scaled_blit_address_generator_tb: errors");
        end
        $finish;
    end

endmodule
